// File: src/psh_pkg.sv
// Shared constants, codes and types of the presmoothed survival / hazard estimator.
// No dependencies; psh_div and the top level import it.
package psh_pkg;

  // Default table depth
  localparam int unsigned MAX_ENTRIES_DEF = 1024;

  // Field widths
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned WGT_W    = 16;
  localparam int unsigned EST_W    = 32;
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned IN_TDATA_W = 64;

  // Term numerator: weight Q1.15 moved to Q.24
  localparam int unsigned WGT_SHIFT = 9;
  localparam int unsigned NUM_W     = WGT_W + WGT_SHIFT;
  localparam int unsigned FRAC_W    = 24;

  // Divider: quotient bits retired per cycle
  localparam int unsigned DIV_BITS  = 5;
  localparam int unsigned DIV_STEPS = NUM_W / DIV_BITS;

  localparam logic [EST_W-1:0] ONE_Q24 = EST_W'(1) << FRAC_W;
  localparam logic [EST_W-1:0] EST_MAX = '1;

  // Configuration register indexes
  typedef enum logic {
    REG_MODE  = 1'b0,
    REG_COUNT = 1'b1
  } reg_idx_e;

  // Request kinds (tuser)
  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  // Estimand modes
  typedef enum logic {
    MODE_SURV   = 1'b0,
    MODE_HAZARD = 1'b1
  } mode_e;

  // Query sequencer, one-hot
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_READ  = 6'b000010,
    ST_CHECK = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_MUL   = 6'b010000,
    ST_FIN   = 6'b100000
  } state_e;

endpackage

// File: src/psh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module psh_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/psh_div.sv
// Iterative restoring divider for the per-entry term weight * 2^9 / divisor.
// Depends on psh_pkg for the numerator width and bits retired per cycle.
module psh_div #(
  parameter int unsigned DW = 11
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [psh_pkg::NUM_W-1:0] num_i,
  input  logic [DW-1:0]             den_i,
  output logic                      done_o,
  output logic [psh_pkg::NUM_W-1:0] quo_o
);
  import psh_pkg::*;

  localparam int unsigned SC_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  logic [NUM_W-1:0] num_q, num_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    den_q;
  logic [SC_W-1:0]  step_q;
  logic             busy_q, done_q;

  // Retire DIV_BITS quotient bits
  always_comb begin
    logic [DW:0] trial;
    num_d = num_q;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial = {rem_d, num_d[NUM_W-1]};
      num_d = {num_d[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial = trial - {1'b0, den_q};
        quo_d = {quo_d[NUM_W-2:0], 1'b1};
      end else begin
        quo_d = {quo_d[NUM_W-2:0], 1'b0};
      end
      rem_d = trial[DW-1:0];
    end
  end

  // Operand and partial registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == SC_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + SC_W'(1);
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: src/presmoothed_survival_hazard_estimator.sv
// Top level of the presmoothed survival / cumulative hazard estimator.
// Depends on psh_pkg, psh_ram (entry table) and psh_div (term divider).
//
//  Channel  | Dir | Handshake                  | Payload
//  ---------+-----+----------------------------+-----------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready       | tuser: action; tdata: index, time, weight
//  m_axis   | out | m_axis_tvalid/tready       | tdata: estimate (Q8.24)
//  cfg      | in  | cfg_valid_i/cfg_ready_o    | cfg_index_i, cfg_data_i
//
// A load with an index inside the table is written on acceptance. A query walks the entries in order,
// each one by a table read, a time compare, the term divider and an accumulate step; the walk ends
// at the entry count or at the first entry whose time exceeds the query time.
// Reset clears control and the configuration registers (mode survival, count 1); the table is not cleared.
// A finished estimate waits in the output register; a new request is taken meanwhile.
// Configuration writes are held off while a query runs.
module presmoothed_survival_hazard_estimator #(
  parameter int unsigned MAX_ENTRIES = psh_pkg::MAX_ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [9:0] entry_index, [41:10] time_value, [57:42] weight_value, [63:58] zero
  input  logic [psh_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // [0] action
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [31:0] estimate
  output logic [psh_pkg::EST_W-1:0]      m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_index_i,
  input  logic [psh_pkg::CNT_W-1:0]      cfg_data_i
);
  import psh_pkg::*;

  localparam int unsigned AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned NX  = (CW > CNT_W) ? CW : CNT_W;
  localparam int unsigned IX  = (CW > IDX_W) ? CW : IDX_W;
  localparam int unsigned RW  = TIME_W + WGT_W;
  localparam int unsigned PW  = EST_W + NUM_W;

  state_e state_q, state_d;

  logic              mode_q;
  logic [CNT_W-1:0]  count_q;
  logic [CW-1:0]     n_q, n_d;
  logic [CW-1:0]     j_q;
  logic [TIME_W-1:0] x_q;
  logic [EST_W-1:0]  acc_q;
  logic [EST_W-1:0]  out_q;
  logic              out_valid_q;

  logic [IDX_W-1:0]  in_idx;
  logic [TIME_W-1:0] in_time;
  logic [WGT_W-1:0]  in_wgt;
  logic              in_acc, is_load, is_query, we;
  logic [RW-1:0]     rdata;
  logic [TIME_W-1:0] rd_time;
  logic [WGT_W-1:0]  rd_wgt;
  logic              div_start, div_done;
  logic [NUM_W-1:0]  quo;
  logic [NX-1:0]     cnt_ext;
  logic [EST_W:0]    hsum;
  logic [NUM_W-1:0]  fac;
  logic [PW-1:0]     prod;
  logic              out_free;

  // Unpack the request
  assign in_idx  = s_axis_tdata[IDX_W-1:0];
  assign in_time = s_axis_tdata[IDX_W +: TIME_W];
  assign in_wgt  = s_axis_tdata[IDX_W+TIME_W +: WGT_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign is_load  = in_acc && (s_axis_tuser == ACT_LOAD);
  assign is_query = in_acc && (s_axis_tuser == ACT_QUERY);
  assign we       = is_load && (IX'(in_idx) < IX'(MAX_ENTRIES));

  // Clamp the entry count to the table depth
  assign cnt_ext = NX'(count_q);
  assign n_d = (cnt_ext > NX'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(cnt_ext);

  // Configuration registers, written only between queries
  assign cfg_ready_o = (state_q == ST_IDLE);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_SURV;
      count_q <= CNT_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_MODE:  mode_q  <= cfg_data_i[0];
        REG_COUNT: count_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // Entry table: time in the low bits, weight above
  psh_ram #(
    .WIDTH(RW),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (AW'(in_idx)),
    .wdata_i ({in_wgt, in_time}),
    .re_i    (state_q == ST_READ),
    .raddr_i (j_q[AW-1:0]),
    .rdata_o (rdata)
  );
  assign rd_time = rdata[TIME_W-1:0];
  assign rd_wgt  = rdata[TIME_W +: WGT_W];

  // Term divider
  assign div_start = (state_q == ST_CHECK) && (rd_time <= x_q);
  psh_div #(
    .DW(CW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({rd_wgt, {WGT_SHIFT{1'b0}}}),
    .den_i   (n_q - j_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Accumulate candidates
  assign hsum = {1'b0, acc_q} + (EST_W+1)'(quo);
  assign fac  = (quo >= NUM_W'(ONE_Q24)) ? '0 : NUM_W'(ONE_Q24) - quo;
  assign prod = PW'(acc_q) * PW'(fac);

  assign out_free = !out_valid_q || m_axis_tready;

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (is_query) state_d = ST_READ;
      ST_READ:  state_d = (j_q >= n_q) ? ST_FIN : ST_CHECK;
      ST_CHECK: state_d = (rd_time <= x_q) ? ST_DIV : ST_FIN;
      ST_DIV:   if (div_done) state_d = ST_MUL;
      ST_MUL:   state_d = ST_READ;
      ST_FIN:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      j_q         <= '0;
    end else begin
      state_q <= state_d;
      if (is_query) begin
        j_q <= '0;
      end else if (state_q == ST_MUL) begin
        j_q <= j_q + CW'(1);
      end
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Query payload: bound, time, accumulator, result
  always_ff @(posedge clk_i) begin
    if (is_query) begin
      n_q   <= n_d;
      x_q   <= in_time;
      acc_q <= (mode_q == MODE_HAZARD) ? '0 : ONE_Q24;
    end else if (state_q == ST_MUL) begin
      if (mode_q == MODE_HAZARD) begin
        acc_q <= hsum[EST_W] ? EST_MAX : hsum[EST_W-1:0];
      end else begin
        acc_q <= prod[FRAC_W +: EST_W];
      end
    end
    if (state_q == ST_FIN && out_free) begin
      out_q <= acc_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule
